>>> rtl/polygon_area_quantizer_assert.svh
// Assertion macros used by the checker of polygon_area_quantizer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef POLYGON_AREA_QUANTIZER_ASSERT_SVH
`define POLYGON_AREA_QUANTIZER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PAQ_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PAQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/paq_pkg.sv
package paq_pkg;

    // field widths
    localparam int COORD_BITS = 12;
    localparam int SUM_BITS   = 48;
    localparam int DIM_BITS   = 13;
    localparam int LVL_BITS   = 16;
    localparam int AREA_BITS  = 47;

    // derived widths
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int WIDE_BITS  = (PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS;
    localparam int MAG_BITS   = (SUM_BITS > AREA_BITS) ? SUM_BITS : AREA_BITS;
    localparam int DENOM_BITS = 2 * DIM_BITS + 1;
    localparam int QPROD_BITS = DENOM_BITS + LVL_BITS;
    localparam int DIV_STEPS  = LVL_BITS;
    localparam int STEP_BITS  = $clog2(DIV_STEPS);

    // APB map
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SUM_BITS-1:0]   sum_t;
    typedef logic [AREA_BITS-1:0]  area_t;
    typedef logic [LVL_BITS-1:0]   level_t;
    typedef logic [DIM_BITS-1:0]   dim_t;
    typedef logic [DENOM_BITS-1:0] denom_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [DATA_BITS-1:0]  data_t;

    localparam addr_t REG_WIDTH  = 4'h0;
    localparam addr_t REG_HEIGHT = 4'h4;
    localparam addr_t REG_LEVELS = 4'h8;

    localparam dim_t   WIDTH_RESET  = 13'd640;
    localparam dim_t   HEIGHT_RESET = 13'd480;
    localparam level_t LEVELS_RESET = 16'd100;

    localparam area_t AREA_MAX = {AREA_BITS{1'b1}};

    typedef struct packed {
        dim_t   width;
        dim_t   height;
        level_t levels;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic take_vertex;
        logic close_poly;
        logic calc_mag;
        logic calc_level;
        logic div_step;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
    } status_t;

endpackage

>>> rtl/paq_if.sv
interface paq_vertex_if;
    import paq_pkg::*;

    logic   valid;
    logic   ready;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;

    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface paq_result_if;
    import paq_pkg::*;

    logic   valid;
    logic   ready;
    area_t  doubled_area;
    level_t area_level;

    modport source (output valid, doubled_area, area_level, input ready);
    modport sink   (input valid, doubled_area, area_level, output ready);
endinterface

>>> rtl/paq_regs.sv
module paq_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  paq_pkg::addr_t paddr,
    input  paq_pkg::data_t pwdata,
    output paq_pkg::data_t prdata,
    output logic           pready,
    output paq_pkg::cfg_t  cfg
);
    import paq_pkg::*;

    dim_t   width_reg;
    dim_t   height_reg;
    level_t levels_reg;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            levels_reg <= LEVELS_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                REG_WIDTH:  width_reg  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_BITS-1:0];
                REG_LEVELS: levels_reg <= pwdata[LVL_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_WIDTH:  prdata = DATA_BITS'(width_reg);
            REG_HEIGHT: prdata = DATA_BITS'(height_reg);
            REG_LEVELS: prdata = DATA_BITS'(levels_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.levels = levels_reg;

endmodule

>>> rtl/paq_dp.sv
module paq_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  paq_pkg::cmd_t    cmd,
    input  paq_pkg::cfg_t    cfg,
    input  paq_pkg::coord_t  vertex_x,
    input  paq_pkg::coord_t  vertex_y,
    output paq_pkg::status_t status,
    output paq_pkg::area_t   doubled_area,
    output paq_pkg::level_t  area_level
);
    import paq_pkg::*;

    coord_t first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    sum_t   sum_reg;
    logic   in_poly_reg;
    area_t  area_reg;
    denom_t denom_reg;
    denom_t rem_reg;
    level_t quo_reg;
    area_t  out_area_reg;
    level_t out_level_reg;

    // shared cross-product unit: prev x b
    coord_t                 bx, by;
    logic [PROD_BITS-1:0]   prod_a, prod_b;
    logic [WIDE_BITS-1:0]   term_wide;
    sum_t                   term;
    sum_t                   sum_plus;

    // closing arithmetic
    sum_t                   mag;
    logic [MAG_BITS-1:0]    mag_wide;
    area_t                  area_sat;
    logic [2*DIM_BITS-1:0]  dim_prod;
    logic                   lvl_zero, lvl_sat;
    logic [QPROD_BITS-1:0]  qprod;
    logic [DENOM_BITS:0]    trial;
    logic                   trial_ge;
    logic [DENOM_BITS:0]    trial_diff;

    always_comb
    begin
        bx        = cmd.close_poly ? first_x_reg : vertex_x;
        by        = cmd.close_poly ? first_y_reg : vertex_y;
        prod_a    = PROD_BITS'(prev_x_reg) * PROD_BITS'(by);
        prod_b    = PROD_BITS'(prev_y_reg) * PROD_BITS'(bx);
        term_wide = WIDE_BITS'(prod_a) - WIDE_BITS'(prod_b);
        term      = term_wide[SUM_BITS-1:0];
        sum_plus  = sum_reg + term;

        mag      = sum_reg[SUM_BITS-1] ? (~sum_reg + SUM_BITS'(1)) : sum_reg;
        mag_wide = MAG_BITS'(mag);
        area_sat = (mag_wide > MAG_BITS'(AREA_MAX)) ? AREA_MAX : mag_wide[AREA_BITS-1:0];
        dim_prod = (2*DIM_BITS)'(cfg.width) * (2*DIM_BITS)'(cfg.height);

        lvl_zero = (cfg.levels == '0);
        lvl_sat  = (denom_reg == '0) || (area_reg >= AREA_BITS'(denom_reg));
        qprod    = QPROD_BITS'(area_reg[DENOM_BITS-1:0]) * QPROD_BITS'(cfg.levels);

        trial      = {rem_reg, quo_reg[LVL_BITS-1]};
        trial_ge   = trial >= (DENOM_BITS+1)'(denom_reg);
        trial_diff = trial - (DENOM_BITS+1)'(denom_reg);
    end

    assign status.need_div = !lvl_zero && !lvl_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_poly_reg <= 1'b0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            if (cmd.take_vertex)
            begin
                if (!in_poly_reg)
                begin
                    first_x_reg <= vertex_x;
                    first_y_reg <= vertex_y;
                    sum_reg     <= '0;
                end
                else
                begin
                    sum_reg <= sum_plus;
                end
                prev_x_reg  <= vertex_x;
                prev_y_reg  <= vertex_y;
                in_poly_reg <= 1'b1;
            end
            else if (cmd.close_poly)
            begin
                sum_reg     <= sum_plus;
                in_poly_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.calc_mag)
        begin
            area_reg  <= area_sat;
            denom_reg <= {dim_prod, 1'b0};
        end
        if (cmd.calc_level)
        begin
            if (lvl_zero)
                quo_reg <= '0;
            else if (lvl_sat)
                quo_reg <= cfg.levels;
            else
            begin
                rem_reg <= qprod[QPROD_BITS-1:LVL_BITS];
                quo_reg <= qprod[LVL_BITS-1:0];
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[DENOM_BITS-1:0] : trial[DENOM_BITS-1:0];
            quo_reg <= {quo_reg[LVL_BITS-2:0], trial_ge};
        end
        if (cmd.load_out)
        begin
            out_area_reg  <= area_reg;
            out_level_reg <= quo_reg;
        end
    end

    assign doubled_area = out_area_reg;
    assign area_level   = out_level_reg;

endmodule

>>> rtl/paq_ctrl.sv
module paq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  paq_pkg::status_t status,
    output paq_pkg::cmd_t    cmd
);
    import paq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_MAG,
        ST_LEVEL,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 in_fire, slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd.take_vertex = in_fire;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_last)
                    state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                cmd.close_poly = 1'b1;
                state_next     = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.calc_mag = 1'b1;
                state_next   = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                cmd.calc_level = 1'b1;
                cnt_next       = '0;
                state_next     = status.need_div ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + STEP_BITS'(1);
                if (cnt_reg == STEP_BITS'(DIV_STEPS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/polygon_area_quantizer.sv
// Sequencing: the vertex port stays ready across a non-last vertex; after its last vertex a
//   polygon passes close, magnitude, level, the 16-step restoring divider when the level needs it, and finish.
// Flow: the vertex port is held off during close/magnitude/level/divide and while finish
//   waits on an unread result word.
// Reset: rst_n async active low; clears the vertex/sum state, sequencer and output valid,
//   and loads width 640, height 480, levels 100.
module polygon_area_quantizer (
    input  logic           clk,
    input  logic           rst_n,
    paq_vertex_if.sink     vertex_in,
    paq_result_if.source   result_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  paq_pkg::addr_t paddr,
    input  paq_pkg::data_t pwdata,
    output paq_pkg::data_t prdata,
    output logic           pready
);
    import paq_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // APB registers: width at 0x0, height at 0x4, levels at 0x8
    paq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: idle takes vertex words; a last vertex walks
    // close -> magnitude -> level -> (divide) -> finish.
    paq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vertex_in.valid),
        .in_last   (vertex_in.last_vertex),
        .in_ready  (vertex_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: shoelace accumulator with one shared cross-product unit,
    // |sum| with saturation, 2*w*h, level multiply and quotient divider,
    // and the output word register.
    paq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .vertex_x     (vertex_in.vertex_x),
        .vertex_y     (vertex_in.vertex_y),
        .status       (status),
        .doubled_area (result_out.doubled_area),
        .area_level   (result_out.area_level)
    );

endmodule

>>> rtl/paq_checker.sv
`include "polygon_area_quantizer_assert.svh"

module paq_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_last,
    input logic            out_valid,
    input logic            out_ready,
    input paq_pkg::area_t  doubled_area,
    input paq_pkg::level_t area_level
);
    import paq_pkg::*;

    // closing a polygon always stalls the vertex port
    `PAQ_ASSERT_NEXT(a_last_stalls, in_valid && in_ready && in_last, !in_ready, "no stall after last vertex")

    // a mid-polygon vertex never stalls the vertex port
    `PAQ_ASSERT_NEXT(a_vertex_stream, in_valid && in_ready && !in_last, in_ready, "stall on mid-polygon vertex")

    // a new result word is only loaded while the vertex port is held off
    `PAQ_ASSERT_NOW(a_load_busy, $rose(out_valid), $past(!in_ready), "result loaded while idle")

    // a waiting result word holds
    `PAQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(doubled_area) && $stable(area_level), "result word changed while stalled")

endmodule

bind polygon_area_quantizer paq_checker u_paq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (vertex_in.valid),
    .in_ready     (vertex_in.ready),
    .in_last      (vertex_in.last_vertex),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .doubled_area (result_out.doubled_area),
    .area_level   (result_out.area_level)
);

>>> bench/polygon_area_quantizer_tb.sv
`timescale 1ns / 100ps

module polygon_area_quantizer_tb;
    import paq_pkg::*;

    // cycle budget for the whole run, far above the slowest legal schedule
    localparam int CYCLE_LIMIT = 200000;
    // length of the long receiver hold-off used to back the block up
    localparam int LONG_STALL  = 300;
    // settle time after the last result, covering the divider path
    localparam int TAIL_CYCLES = 32;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } vertex_t;

    typedef struct packed {
        area_t  area;
        level_t level;
    } area_result_t;

    // how random polygons place their vertices
    typedef enum int {SHAPE_ANY, SHAPE_CORNER, SHAPE_LOCAL} shape_t;

    logic clk = 1'b0;
    logic rst_n;

    logic  psel;
    logic  penable;
    logic  pwrite;
    addr_t paddr;
    data_t pwdata;
    data_t prdata;
    logic  pready;

    paq_vertex_if vtx_bus ();
    paq_result_if res_bus ();

    polygon_area_quantizer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex_in  (vtx_bus),
        .result_out (res_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus and expectation stores
    // ------------------------------------------------------------------
    vertex_t      vertex_q[$];        // vertices waiting to be offered
    area_result_t area_expect_q[$];   // predicted result words, oldest first

    int   send_idle_pct  = 0;  // chance the sender leaves a cycle empty
    int   recv_stall_pct = 0;  // chance the receiver drops ready
    logic recv_hold      = 1'b0;
    event long_stall_ev;

    logic vtx_taken = 1'b0;    // vertex word accepted at the last rising edge
    int   fail_count  = 0;
    int   cycle_count = 0;

    // ------------------------------------------------------------------
    // Shoelace predictor: own copy of the registers and polygon state
    // ------------------------------------------------------------------
    dim_t   cfg_width  = WIDTH_RESET;
    dim_t   cfg_height = HEIGHT_RESET;
    level_t cfg_levels = LEVELS_RESET;

    coord_t poly_first_x = '0;
    coord_t poly_first_y = '0;
    coord_t poly_prev_x  = '0;
    coord_t poly_prev_y  = '0;
    sum_t   poly_sum     = '0;
    logic   poly_open    = 1'b0;

    // one edge of the shoelace sum; wraps at the sum width like the hardware
    function automatic sum_t cross_term(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        return sum_t'(ax) * sum_t'(by) - sum_t'(ay) * sum_t'(bx);
    endfunction

    task automatic shoelace_fold(input vertex_t v);
        sum_t         mag;
        area_t        area;
        logic [63:0]  denom;
        logic [63:0]  quot;
        area_result_t r;

        if (!poly_open)
        begin
            poly_first_x = v.x;
            poly_first_y = v.y;
            poly_sum     = '0;
            poly_open    = 1'b1;
        end
        else
            poly_sum = poly_sum + cross_term(poly_prev_x, poly_prev_y, v.x, v.y);
        poly_prev_x = v.x;
        poly_prev_y = v.y;

        if (v.last)
        begin
            // close back to the first vertex
            poly_sum = poly_sum + cross_term(poly_prev_x, poly_prev_y,
                                             poly_first_x, poly_first_y);
            mag  = poly_sum[SUM_BITS-1] ? -poly_sum : poly_sum;
            area = (mag > AREA_MAX) ? AREA_MAX : mag[AREA_BITS-1:0];

            // level = floor(D * levels / (2*w*h)); zero levels gives 0, zero divisor or D >= divisor saturates
            denom = 64'd2 * cfg_width * cfg_height;
            if (cfg_levels == '0)
                quot = '0;
            else if (denom == '0 || 64'(area) >= denom)
                quot = 64'(cfg_levels);
            else
                quot = (64'(area) * cfg_levels) / denom;

            r.area  = area;
            r.level = level_t'(quot);
            area_expect_q.push_back(r);
            poly_open = 1'b0;
            poly_sum  = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Vertex driver: changes on the falling edge, advances only after an
    // accept seen at the rising edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!vtx_bus.valid || vtx_taken))
        begin
            if (vertex_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                vtx_bus.valid       <= 1'b1;
                vtx_bus.vertex_x    <= vertex_q[0].x;
                vtx_bus.vertex_y    <= vertex_q[0].y;
                vtx_bus.last_vertex <= vertex_q[0].last;
                void'(vertex_q.pop_front());
            end
            else
                vtx_bus.valid <= 1'b0;
        end
    end

    // result receiver: random stalls plus the long hold-off
    always @(negedge clk)
        res_bus.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

    // long hold-off, counted here so the sender keeps running meanwhile
    always
    begin
        @(long_stall_ev);
        recv_hold = 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        recv_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted vertices, check accepted result words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        area_result_t want;

        vtx_taken <= rst_n && vtx_bus.valid && vtx_bus.ready;
        if (rst_n && vtx_bus.valid && vtx_bus.ready)
            shoelace_fold('{x: vtx_bus.vertex_x, y: vtx_bus.vertex_y,
                            last: vtx_bus.last_vertex});

        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (area_expect_q.size() == 0)
            begin
                $error("unexpected result word: doubled_area=%0d area_level=%0d",
                       res_bus.doubled_area, res_bus.area_level);
                fail_count++;
            end
            else
            begin
                want = area_expect_q.pop_front();
                if (res_bus.doubled_area !== want.area)
                begin
                    $error("doubled_area: expected %0d, got %0d",
                           want.area, res_bus.doubled_area);
                    fail_count++;
                end
                if (res_bus.area_level !== want.level)
                begin
                    $error("area_level: expected %0d, got %0d",
                           want.level, res_bus.area_level);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Helpers for the sequence
    // ------------------------------------------------------------------
    task automatic push_vertex(input coord_t x, input coord_t y, input logic last);
        vertex_t v;

        v.x    = x;
        v.y    = y;
        v.last = last;
        vertex_q.push_back(v);
    endtask

    task automatic queue_polygon(input int n, input shape_t shape);
        coord_t base_x;
        coord_t base_y;
        coord_t px;
        coord_t py;

        base_x = coord_t'($urandom);
        base_y = coord_t'($urandom);
        for (int i = 0; i < n; i++)
        begin
            case (shape)
                SHAPE_CORNER:
                begin
                    px = ($urandom_range(1) != 0) ? {COORD_BITS{1'b1}} : '0;
                    py = ($urandom_range(1) != 0) ? {COORD_BITS{1'b1}} : '0;
                end
                SHAPE_LOCAL:
                begin
                    // small shape around a random origin, may wrap at the edge
                    px = base_x + coord_t'($urandom_range(63));
                    py = base_y + coord_t'($urandom_range(63));
                end
                default:
                begin
                    px = coord_t'($urandom);
                    py = coord_t'($urandom);
                end
            endcase
            push_vertex(px, py, i == n - 1);
        end
    endtask

    // whole polygons only, so every phase ends with the state closed
    task automatic queue_random(input int count);
        int added;
        int n;
        int pick;

        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                n = 1;
            else if (pick < 15)
                n = $urandom_range(60, 20);
            else
                n = $urandom_range(12, 2);
            queue_polygon(n, shape_t'($urandom_range(2)));
            added += n;
        end
    endtask

    // wait for the sender to run dry and every predicted word to arrive
    task automatic drain;
        while (vertex_q.size() != 0 || vtx_bus.valid || area_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input addr_t addr, input data_t data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (addr)
            REG_WIDTH:  cfg_width  = data[DIM_BITS-1:0];
            REG_HEIGHT: cfg_height = data[DIM_BITS-1:0];
            REG_LEVELS: cfg_levels = data[LVL_BITS-1:0];
            default:    ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input dim_t w, input dim_t h, input level_t lv);
        apb_write(REG_WIDTH,  data_t'(w));
        apb_write(REG_HEIGHT, data_t'(h));
        apb_write(REG_LEVELS, data_t'(lv));
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(count);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        vtx_bus.valid       = 1'b0;
        vtx_bus.vertex_x    = '0;
        vtx_bus.vertex_y    = '0;
        vtx_bus.last_vertex = 1'b0;
        res_bus.ready       = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset configuration (640x480, 100 levels)
        // single-vertex polygons close on themselves
        push_vertex(12'd0, 12'd0, 1'b1);
        push_vertex(12'hFFF, 12'hFFF, 1'b1);
        // full coordinate range square: far above the frame, level saturates
        push_vertex(12'd0, 12'd0, 1'b0);
        push_vertex(12'hFFF, 12'd0, 1'b0);
        push_vertex(12'hFFF, 12'hFFF, 1'b0);
        push_vertex(12'd0, 12'hFFF, 1'b1);
        // half frame: level 50
        push_vertex(12'd0, 12'd0, 1'b0);
        push_vertex(12'd320, 12'd0, 1'b0);
        push_vertex(12'd320, 12'd480, 1'b0);
        push_vertex(12'd0, 12'd480, 1'b1);
        // exactly the frame: area equals divisor
        push_vertex(12'd0, 12'd0, 1'b0);
        push_vertex(12'd640, 12'd0, 1'b0);
        push_vertex(12'd640, 12'd480, 1'b0);
        push_vertex(12'd0, 12'd480, 1'b1);
        // opposite winding gives a negative sum
        push_vertex(12'd0, 12'd0, 1'b0);
        push_vertex(12'd0, 12'd10, 1'b0);
        push_vertex(12'd10, 12'd0, 1'b1);
        // two vertices: zero area
        push_vertex(12'd5, 12'd7, 1'b0);
        push_vertex(12'd4000, 12'd3000, 1'b1);
        // alternating bit patterns
        push_vertex(12'hAAA, 12'h555, 1'b0);
        push_vertex(12'h555, 12'hAAA, 1'b0);
        push_vertex(12'hFFF, 12'h000, 1'b1);
        drain();

        // full rate, reset configuration
        run_phase(0, 0, 150);

        // tiny frame, max levels: nearly everything saturates
        load_config(13'd1, 13'd1, 16'hFFFF);
        run_phase(88, 0, 150);

        // widest frame, one level
        load_config(13'h1FFF, 13'h1FFF, 16'd1);
        run_phase(0, 88, 150);

        // zero width: divisor is zero, level is levels
        load_config(13'd0, dim_t'($urandom_range(4096, 1)), level_t'($urandom_range(65535, 1)));
        run_phase(26, 26, 100);

        // zero height and zero levels
        load_config(dim_t'($urandom_range(4096, 1)), 13'd0, 16'd0);
        run_phase(26, 26, 50);
        load_config(dim_t'($urandom_range(4096, 1)), dim_t'($urandom_range(4096, 1)), 16'd0);
        run_phase(0, 0, 50);

        // mid-range frame; receiver holds off long so the block backs up
        load_config(dim_t'($urandom_range(4096, 64)), dim_t'($urandom_range(4096, 64)),
                    level_t'($urandom_range(65535, 1)));
        -> long_stall_ev;
        run_phase(0, 0, 150);

        load_config(dim_t'($urandom_range(4096, 1)), dim_t'($urandom_range(4096, 1)),
                    level_t'($urandom_range(65535, 1)));
        run_phase(26, 26, 150);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
